[design/lfo_mw_pkg.sv]
// lfo_mw_pkg: shared types, codes and constants of the multi-waveform lfo
// holds field widths, waveform, command and register codes, xorshift helpers
// no dependencies
package lfo_mw_pkg;

   localparam int INC_WIDTH       = 33;
   localparam int SAMPLE_WIDTH    = 16;
   localparam int WAVE_WIDTH      = 3;
   localparam int SEED_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [WAVE_WIDTH-1:0] WAVE_SINE     = 3'd0;
   localparam logic [WAVE_WIDTH-1:0] WAVE_TRIANGLE = 3'd1;
   localparam logic [WAVE_WIDTH-1:0] WAVE_SAW      = 3'd2;
   localparam logic [WAVE_WIDTH-1:0] WAVE_SQUARE   = 3'd3;
   localparam logic [WAVE_WIDTH-1:0] WAVE_HOLD     = 3'd4;

   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WAVEFORM   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NOISE_SEED = 1'b1;

   localparam logic [SEED_WIDTH-1:0] NOISE_DEFAULT_SEED = 32'h0123_4567;

   // odd sine polynomial coefficients in q30
   localparam logic [63:0] SIN_C1 = 64'd1686629713;
   localparam logic [63:0] SIN_C3 = 64'd693598670;
   localparam logic [63:0] SIN_C5 = 64'd85569306;
   localparam logic [63:0] SIN_C7 = 64'd5026990;
   localparam logic [63:0] SIN_C9 = 64'd172272;

   function automatic logic [SEED_WIDTH-1:0] xorshift_step(logic [SEED_WIDTH-1:0] x);
      logic [SEED_WIDTH-1:0] y;
      y = x ^ (x << 13);
      y = y ^ (y >> 17);
      y = y ^ (y << 5);
      return y;
   endfunction

   // upper half of the generator minus 32768
   function automatic logic [SAMPLE_WIDTH-1:0] noise_value(logic [SEED_WIDTH-1:0] x);
      return {~x[SEED_WIDTH-1], x[SEED_WIDTH-2:SEED_WIDTH-SAMPLE_WIDTH]};
   endfunction

   localparam logic [SEED_WIDTH-1:0]   RESET_NOISE_STATE = xorshift_step(NOISE_DEFAULT_SEED);
   localparam logic [SAMPLE_WIDTH-1:0] RESET_HELD_NOISE  = noise_value(RESET_NOISE_STATE);

   typedef struct packed {
      logic                    wrapped;
      logic [SAMPLE_WIDTH-1:0] held_noise;
   } stage_type;

endpackage

[design/lfo_mw_phase.sv]
// lfo_mw_phase: phase accumulator, noise generator and first pipeline stage
// uses lfo_mw_pkg for widths, codes and the xorshift helpers
module lfo_mw_phase import lfo_mw_pkg::*; #(
   parameter int PHASE_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic                        cmd,
   input  logic signed [INC_WIDTH-1:0] phase_increment,
   input  logic [WAVE_WIDTH-1:0]       waveform,
   input  logic [SEED_WIDTH-1:0]       noise_seed,
   output logic [PHASE_BITS-1:0]       phase,
   output stage_type                   stage
);

   localparam int SUM_WIDTH = ((PHASE_BITS > INC_WIDTH) ? PHASE_BITS : INC_WIDTH) + 2;

   logic [PHASE_BITS-1:0]   phase_ff, phase_in;
   logic [SEED_WIDTH-1:0]   noise_ff, noise_in;
   logic [SAMPLE_WIDTH-1:0] held_ff, held_in;
   logic                    wrapped_ff, wrapped_in;
   logic [SUM_WIDTH-1:0]    sum;
   logic                    sum_negative;
   logic                    wrap;
   logic [SEED_WIDTH-1:0]   seed_sel;
   logic [SEED_WIDTH-1:0]   noise_next;

   assign sum = {{(SUM_WIDTH-PHASE_BITS){1'b0}}, phase_ff}
              + {{(SUM_WIDTH-INC_WIDTH){phase_increment[INC_WIDTH-1]}}, phase_increment};
   assign sum_negative = sum[SUM_WIDTH-1];
   assign wrap = !sum_negative && (|sum[SUM_WIDTH-2:PHASE_BITS]);

   assign seed_sel   = (noise_seed != '0) ? noise_seed : NOISE_DEFAULT_SEED;
   assign noise_next = xorshift_step((cmd == CMD_RESTART) ? seed_sel : noise_ff);

   always_comb begin
      phase_in   = phase_ff;
      noise_in   = noise_ff;
      held_in    = held_ff;
      wrapped_in = wrapped_ff;
      if (load) begin
         if (cmd == CMD_RESTART) begin
            phase_in = '0;
            noise_in = noise_next;
            held_in  = noise_value(noise_next);
         end else begin
            phase_in   = sum_negative ? '0 : sum[PHASE_BITS-1:0];
            wrapped_in = wrap;
            if (wrap && (waveform == WAVE_HOLD)) begin
               noise_in = noise_next;
               held_in  = noise_value(noise_next);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         noise_ff   <= RESET_NOISE_STATE;
         held_ff    <= RESET_HELD_NOISE;
         wrapped_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         noise_ff   <= noise_in;
         held_ff    <= held_in;
         wrapped_ff <= wrapped_in;
      end
   end

   assign phase            = phase_ff;
   assign stage.wrapped    = wrapped_ff;
   assign stage.held_noise = held_ff;

endmodule

[design/lfo_mw_wave.sv]
// lfo_mw_wave: waveform shaping from the registered phase
// uses lfo_mw_pkg for widths, waveform codes and sine coefficients
module lfo_mw_wave import lfo_mw_pkg::*; #(
   parameter int PHASE_BITS       = 32,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic [PHASE_BITS-1:0]   phase,
   input  logic [WAVE_WIDTH-1:0]   waveform,
   input  logic [SAMPLE_WIDTH-1:0] held_noise,
   output logic [SAMPLE_WIDTH-1:0] sample
);

   localparam int TABLE_ENTRIES = SINE_TABLE_DEPTH + 1;
   localparam int INDEX_WIDTH   = $clog2(TABLE_ENTRIES);
   localparam int SCALE         = 4 * SINE_TABLE_DEPTH;
   localparam int SCALE_WIDTH   = $clog2(SCALE + 1);
   localparam int PROD_WIDTH    = PHASE_BITS + SCALE_WIDTH;

   localparam logic [SCALE_WIDTH-1:0] QUAD1 = SCALE_WIDTH'(SINE_TABLE_DEPTH);
   localparam logic [SCALE_WIDTH-1:0] QUAD2 = SCALE_WIDTH'(2 * SINE_TABLE_DEPTH);
   localparam logic [SCALE_WIDTH-1:0] QUAD3 = SCALE_WIDTH'(3 * SINE_TABLE_DEPTH);
   localparam logic [INDEX_WIDTH-1:0] DEPTH_INDEX = INDEX_WIDTH'(SINE_TABLE_DEPTH);
   localparam logic [PHASE_BITS-1:0]  HALF_PHASE = {1'b1, {(PHASE_BITS-1){1'b0}}};

   function automatic logic [14:0] quarter_sine(int k);
      logic [63:0] z, z2, acc, s, v;
      z   = (64'(k) << 30) / SINE_TABLE_DEPTH;
      z2  = (z * z) >> 30;
      acc = SIN_C9;
      acc = SIN_C7 - ((acc * z2) >> 30);
      acc = SIN_C5 - ((acc * z2) >> 30);
      acc = SIN_C3 - ((acc * z2) >> 30);
      acc = SIN_C1 - ((acc * z2) >> 30);
      s   = (acc * z) >> 30;
      v   = (s * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[14:0];
   endfunction

   logic [14:0] sine_rom [TABLE_ENTRIES];

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_rom
      localparam logic [14:0] ENTRY = quarter_sine(i);
      assign sine_rom[i] = ENTRY;
   end

   logic [PROD_WIDTH-1:0]   scaled_phase;
   logic [SCALE_WIDTH-1:0]  table_pos;
   logic [SCALE_WIDTH-1:0]  quad_base;
   logic [SCALE_WIDTH-1:0]  quad_offset;
   logic [1:0]              quad;
   logic [INDEX_WIDTH-1:0]  rom_index;
   logic [14:0]             rom_value;
   logic [SAMPLE_WIDTH-1:0] sine_sample;
   logic [PHASE_BITS-1:0]   tri_dist;
   logic [16:0]             tri_scaled;
   logic [17:0]             tri_diff;
   logic [SAMPLE_WIDTH-1:0] tri_sample;
   logic [SAMPLE_WIDTH-1:0] saw_sample;
   logic [SAMPLE_WIDTH-1:0] square_sample;

   // sine: quadrant from table position, mirrored lookup
   assign scaled_phase = PROD_WIDTH'(phase) * PROD_WIDTH'(SCALE);
   assign table_pos    = scaled_phase[PROD_WIDTH-1:PHASE_BITS];

   always_comb begin
      if (table_pos >= QUAD3) begin
         quad      = 2'd3;
         quad_base = QUAD3;
      end else if (table_pos >= QUAD2) begin
         quad      = 2'd2;
         quad_base = QUAD2;
      end else if (table_pos >= QUAD1) begin
         quad      = 2'd1;
         quad_base = QUAD1;
      end else begin
         quad      = 2'd0;
         quad_base = '0;
      end
   end

   assign quad_offset = table_pos - quad_base;
   assign rom_index   = quad[0] ? (DEPTH_INDEX - quad_offset[INDEX_WIDTH-1:0])
                                : quad_offset[INDEX_WIDTH-1:0];
   assign rom_value   = sine_rom[rom_index];
   assign sine_sample = quad[1] ? (16'd0 - {1'b0, rom_value}) : {1'b0, rom_value};

   // triangle: distance from mid-phase
   assign tri_dist = phase[PHASE_BITS-1] ? {1'b0, phase[PHASE_BITS-2:0]}
                                         : (HALF_PHASE - phase);
   if (PHASE_BITS >= 17) begin : g_tri_shift
      assign tri_scaled = tri_dist[PHASE_BITS-1:PHASE_BITS-17];
   end else begin : g_tri_widen
      assign tri_scaled = {tri_dist, {(17-PHASE_BITS){1'b0}}};
   end
   assign tri_diff   = 18'd32768 - {1'b0, tri_scaled};
   assign tri_sample = (tri_scaled == '0) ? 16'h7FFF : tri_diff[SAMPLE_WIDTH-1:0];

   assign saw_sample    = {~phase[PHASE_BITS-1], phase[PHASE_BITS-2:PHASE_BITS-SAMPLE_WIDTH]};
   assign square_sample = phase[PHASE_BITS-1] ? 16'h8000 : 16'h7FFF;

   always_comb begin
      case (waveform)
         WAVE_TRIANGLE: sample = tri_sample;
         WAVE_SAW:      sample = saw_sample;
         WAVE_SQUARE:   sample = square_sample;
         WAVE_HOLD:     sample = held_noise;
         default:       sample = sine_sample;
      endcase
   end

endmodule

[design/lfo_multi_waveform_core.sv]
// lfo_multi_waveform_core: top level of the multi-waveform low-frequency oscillator
// instantiates lfo_mw_phase and lfo_mw_wave, uses lfo_mw_pkg
//
// input channel (req_): req_cmd tick or restart, req_phase_increment signed step.
// a transfer happens at a rising edge with req_valid high and req_stall low.
// a tick advances the phase and yields one result on the rsp_ channel:
// rsp_sample in q1.15 and rsp_cycle_wrapped. a restart reseeds the noise
// generator, zeroes the phase and yields no result.
// csr_ port: write csr_write_data to register csr_index (0 waveform,
// 1 noise seed) at an edge with csr_write_enable high; write only while idle.
// a tick's phase add and clamp are registered in the accumulator stage, then
// the waveform shaping and table lookup feed the result register. throughput is
// one item per cycle while the receiver does not stall. when the receiver
// stalls, the result register holds and the accumulator stage can still fill;
// req_stall rises only once both are occupied.
// synchronous reset empties both stages, zeroes the phase, the waveform and seed
// registers and loads the noise generator with its default seed advanced once.
module lfo_multi_waveform_core import lfo_mw_pkg::*; #(
   parameter int SINE_TABLE_DEPTH = 256,
   parameter int PHASE_BITS       = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic signed [INC_WIDTH-1:0]       req_phase_increment,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]    rsp_sample,
   output logic                              rsp_cycle_wrapped,
   input  logic                              csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]         csr_write_data
);

   logic [WAVE_WIDTH-1:0]          waveform_ff, waveform_in;
   logic [SEED_WIDTH-1:0]          noise_seed_ff, noise_seed_in;
   logic                           stage_valid_ff, stage_valid_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff;
   logic                           rsp_wrapped_ff;
   logic                           stage_move;
   logic                           req_take;
   logic [PHASE_BITS-1:0]          phase;
   stage_type                      stage;
   logic [SAMPLE_WIDTH-1:0]        sample;

   always_comb begin
      waveform_in   = waveform_ff;
      noise_seed_in = noise_seed_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WAVEFORM:   waveform_in   = csr_write_data[WAVE_WIDTH-1:0];
            CSR_NOISE_SEED: noise_seed_in = csr_write_data[SEED_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   assign stage_move     = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall      = stage_valid_ff && !stage_move;
   assign req_take       = req_valid && !req_stall;
   assign stage_valid_in = (req_take && (req_cmd == CMD_TICK)) || (stage_valid_ff && !stage_move);
   assign rsp_valid_in   = stage_move || (rsp_valid_ff && rsp_stall);

   lfo_mw_phase #(
      .PHASE_BITS (PHASE_BITS)
   ) u_phase (
      .clock           (clock),
      .reset           (reset),
      .load            (req_take),
      .cmd             (req_cmd),
      .phase_increment (req_phase_increment),
      .waveform        (waveform_ff),
      .noise_seed      (noise_seed_ff),
      .phase           (phase),
      .stage           (stage)
   );

   lfo_mw_wave #(
      .PHASE_BITS       (PHASE_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_wave (
      .phase      (phase),
      .waveform   (waveform_ff),
      .held_noise (stage.held_noise),
      .sample     (sample)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff    <= WAVE_SINE;
         noise_seed_ff  <= '0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         waveform_ff    <= waveform_in;
         noise_seed_ff  <= noise_seed_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_move) begin
         rsp_sample_ff  <= sample;
         rsp_wrapped_ff <= stage.wrapped;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample        = rsp_sample_ff;
   assign rsp_cycle_wrapped = rsp_wrapped_ff;

endmodule

[design/lfo_mw_checker.sv]
// lfo_mw_checker: port-level assertions for lfo_multi_waveform_core
// uses lfo_mw_pkg for widths, bound to the top level at the end of this file
module lfo_mw_checker import lfo_mw_pkg::*; (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_sample,
   input logic                           rsp_cycle_wrapped
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample) && $stable(rsp_cycle_wrapped))
      else $error("stalled result changed");

   // input backs up only when the result register is full and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   // reset leaves the result register empty and the input unstalled
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

bind lfo_multi_waveform_core lfo_mw_checker u_checker (.*);
